/* hw/rtl/lmr_pkg.sv */
package lmr_pkg;

    // Build-time sizing
    localparam int LEVEL_STEPS = 7;
    localparam int WEAR_SLOTS  = 32;
    localparam int MODE_SLOTS  = 8;

    // Fixed thresholds of the regulation logic
    localparam logic [4:0] FAST_PRESS_MASK  = 5'h1f;
    localparam logic [4:0] FAST_PRESS_LIMIT = 5'd9;
    localparam logic [7:0] HOT_TICKS        = 8'd15;
    localparam logic [7:0] HOT_MAX          = 8'hff;
    localparam logic [3:0] LOW_TICKS        = 4'd8;

    // Item kinds
    localparam logic FUNC_POWER_ON = 1'b0;
    localparam logic FUNC_TICK     = 1'b1;

    // Press kinds (code three acts as long)
    localparam logic [1:0] PRESS_SHORT  = 2'd0;
    localparam logic [1:0] PRESS_MEDIUM = 2'd1;
    localparam logic [1:0] PRESS_LONG   = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_MODE_LEVELS   = 3'd0;
    localparam logic [2:0] REG_MODE_COUNT    = 3'd1;
    localparam logic [2:0] REG_MEMORY_EN     = 3'd2;
    localparam logic [2:0] REG_MEDIUM_EN     = 3'd3;
    localparam logic [2:0] REG_TEMP_LIMIT    = 3'd4;
    localparam logic [2:0] REG_LOW_VOLTAGE   = 3'd5;
    localparam logic [2:0] REG_THERMAL_EN    = 3'd6;
    localparam logic [2:0] REG_BATTERY_EN    = 3'd7;

    // Register reset values
    localparam logic [63:0] MODE_LEVELS_RESET = 64'd460039426305;
    localparam logic [3:0]  MODE_COUNT_RESET  = 4'd5;
    localparam logic [7:0]  TEMP_LIMIT_RESET  = 8'd79;
    localparam logic [7:0]  LOW_VOLTAGE_RESET = 8'd128;

    typedef struct packed {
        logic       func;
        logic [1:0] press_kind;
        logic [7:0] temperature;
        logic [7:0] voltage;
        logic       voltage_valid;
    } lmr_in_t;

    typedef struct packed {
        logic [7:0] level;
        logic [7:0] recovery_level;
        logic [2:0] mode_number;
        logic [4:0] slot;
        logic       config_request;
        logic       shutdown;
    } lmr_out_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [63:0] mode_levels;
        logic [3:0]  mode_count;
        logic        memory_enable;
        logic        medium_press_enable;
        logic [7:0]  temp_limit;
        logic [7:0]  low_voltage_level;
        logic        thermal_enable;
        logic        battery_enable;
    } lmr_cfg_t;

endpackage

/* hw/rtl/lmr_cfg.sv */
module lmr_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output lmr_pkg::lmr_cfg_t cfg
);
    import lmr_pkg::*;

    lmr_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_levels         <= MODE_LEVELS_RESET;
            cfg_reg.mode_count          <= MODE_COUNT_RESET;
            cfg_reg.memory_enable       <= 1'b0;
            cfg_reg.medium_press_enable <= 1'b0;
            cfg_reg.temp_limit          <= TEMP_LIMIT_RESET;
            cfg_reg.low_voltage_level   <= LOW_VOLTAGE_RESET;
            cfg_reg.thermal_enable      <= 1'b1;
            cfg_reg.battery_enable      <= 1'b1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MODE_LEVELS: cfg_reg.mode_levels         <= pwdata;
                REG_MODE_COUNT:  cfg_reg.mode_count          <= pwdata[3:0];
                REG_MEMORY_EN:   cfg_reg.memory_enable       <= pwdata[0];
                REG_MEDIUM_EN:   cfg_reg.medium_press_enable <= pwdata[0];
                REG_TEMP_LIMIT:  cfg_reg.temp_limit          <= pwdata[7:0];
                REG_LOW_VOLTAGE: cfg_reg.low_voltage_level   <= pwdata[7:0];
                REG_THERMAL_EN:  cfg_reg.thermal_enable      <= pwdata[0];
                REG_BATTERY_EN:  cfg_reg.battery_enable      <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_MODE_LEVELS: prdata = cfg_reg.mode_levels;
            REG_MODE_COUNT:  prdata = {60'd0, cfg_reg.mode_count};
            REG_MEMORY_EN:   prdata = {63'd0, cfg_reg.memory_enable};
            REG_MEDIUM_EN:   prdata = {63'd0, cfg_reg.medium_press_enable};
            REG_TEMP_LIMIT:  prdata = {56'd0, cfg_reg.temp_limit};
            REG_LOW_VOLTAGE: prdata = {56'd0, cfg_reg.low_voltage_level};
            REG_THERMAL_EN:  prdata = {63'd0, cfg_reg.thermal_enable};
            REG_BATTERY_EN:  prdata = {63'd0, cfg_reg.battery_enable};
            default:         prdata = 64'd0;
        endcase
    end

endmodule

/* hw/rtl/light_mode_regulator.sv */
// Mode controller and output regulator for a single-channel LED driver.
// Input channel (item_valid / item_stall / item): one beat is either a
// power-on carrying the press kind, or a regulation tick carrying averaged
// temperature and voltage samples. Output channel (result_valid /
// result_stall / result): exactly one beat per input beat, in order, with
// the driven level, recovery goal, mode index, wear slot, config request
// and shutdown flag.
// A beat accepted at a clock edge is registered and on result right after
// that edge, and can be taken at the next edge. Throughput is one beat per
// cycle while the receiver does not stall; the only loop is the mode and
// regulation state, updated at the accepting edge.
// When the receiver stalls, the finished beat holds in the result register
// and item_stall rises until it is taken; an accept and a take may happen
// at the same edge.
// Reset clears all mode/regulation state to zero (mode 0, level off, slot
// 0) and loads the default register values; no result is pending.
// Registers are written over the APB port at byte address 8*index.
module light_mode_regulator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  lmr_pkg::lmr_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output lmr_pkg::lmr_out_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import lmr_pkg::*;

    lmr_cfg_t cfg;

    lmr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // State
    logic [2:0] mode_index_reg,   mode_index_next;
    logic [4:0] fast_count_reg,   fast_count_next;
    logic [4:0] slot_reg,         slot_next;
    logic [7:0] actual_reg,       actual_next;
    logic [7:0] goal_reg,         goal_next;
    logic [7:0] hot_count_reg,    hot_count_next;
    logic [3:0] low_count_reg,    low_count_next;
    logic       off_reg,          off_next;
    logic       valid_reg;
    lmr_out_t   result_reg,       result_next;

    logic       accept;

    // Handshake: take a beat whenever the result slot is free or draining
    assign item_stall   = valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    // Mode stepping helpers
    logic [3:0] used_modes;
    logic [3:0] idx_plus;
    logic [2:0] idx_fwd;
    logic [2:0] idx_back;
    logic [3:0] used_minus;
    logic [7:0] slot_plus;
    logic [4:0] fast_short;
    logic [7:0] hot_inc;
    logic [3:0] low_inc;
    logic [7:0] level_thermal;
    logic [2:0] mode_sel;
    logic [4:0] fast_sel;
    logic       cfg_req;

    always_comb
    begin
        if (cfg.mode_count == 4'd0)
            used_modes = 4'd1;
        else if (cfg.mode_count > 4'(MODE_SLOTS))
            used_modes = 4'(MODE_SLOTS);
        else
            used_modes = cfg.mode_count;

        idx_plus   = {1'b0, mode_index_reg} + 4'd1;
        idx_fwd    = (idx_plus >= used_modes) ? 3'd0 : idx_plus[2:0];
        used_minus = used_modes - 4'd1;

        if ({1'b0, mode_index_reg} == used_modes)
            idx_back = 3'd0;
        else if (mode_index_reg != 3'd0)
            idx_back = mode_index_reg - 3'd1;
        else
            idx_back = used_minus[2:0];

        slot_plus  = {3'b000, slot_reg} + 8'd1;
        fast_short = (fast_count_reg + 5'd1) & FAST_PRESS_MASK;
    end

    // Next state and result for one beat
    always_comb
    begin
        mode_index_next = mode_index_reg;
        fast_count_next = fast_count_reg;
        slot_next       = slot_reg;
        actual_next     = actual_reg;
        goal_next       = goal_reg;
        hot_count_next  = hot_count_reg;
        low_count_next  = low_count_reg;
        off_next        = off_reg;
        cfg_req         = 1'b0;
        mode_sel        = mode_index_reg;
        fast_sel        = 5'd0;
        hot_inc         = hot_count_reg;
        low_inc         = low_count_reg;
        level_thermal   = actual_reg;

        if (item.func == FUNC_POWER_ON)
        begin
            // Press handling
            case (item.press_kind)
                PRESS_SHORT:
                begin
                    fast_sel = fast_short;
                    mode_sel = idx_fwd;
                end
                PRESS_MEDIUM:
                begin
                    mode_sel = cfg.medium_press_enable ? idx_back : idx_fwd;
                end
                default:
                begin
                    mode_sel = cfg.memory_enable ? mode_index_reg : 3'd0;
                end
            endcase

            // Wear-leveling slot wraps at the slot count
            if (slot_plus >= 8'(WEAR_SLOTS) || slot_plus > 8'd31)
                slot_next = 5'd0;
            else
                slot_next = slot_plus[4:0];

            // Too many fast presses: config request, back to first mode
            if (fast_sel > FAST_PRESS_LIMIT)
            begin
                cfg_req         = 1'b1;
                fast_count_next = 5'd0;
                mode_index_next = 3'd0;
            end
            else
            begin
                fast_count_next = fast_sel;
                mode_index_next = mode_sel;
            end

            actual_next    = cfg.mode_levels[{mode_index_next, 3'b000} +: 8];
            goal_next      = actual_next;
            hot_count_next = 8'd0;
            low_count_next = 4'd0;
            off_next       = 1'b0;
        end
        else if (!off_reg)
        begin
            fast_count_next = 5'd0;

            // Thermal step-down and recovery
            if (cfg.thermal_enable)
            begin
                if (item.temperature >= cfg.temp_limit)
                begin
                    hot_inc = (hot_count_reg < HOT_MAX) ? hot_count_reg + 8'd1 : hot_count_reg;
                    if (hot_inc > HOT_TICKS && actual_reg > 8'(LEVEL_STEPS / 8))
                    begin
                        level_thermal  = actual_reg - 8'd1;
                        hot_count_next = 8'd0;
                    end
                    else
                    begin
                        hot_count_next = hot_inc;
                    end
                end
                else
                begin
                    hot_count_next = 8'd0;
                    if (cfg.temp_limit >= 8'd2 &&
                        item.temperature < cfg.temp_limit - 8'd2 &&
                        actual_reg < goal_reg)
                        level_thermal = actual_reg + 8'd1;
                end
            end
            else
            begin
                hot_count_next = 8'd0;
            end
            actual_next = level_thermal;

            // Low-battery step-down and shutdown
            if (!cfg.battery_enable)
            begin
                low_count_next = 4'd0;
            end
            else if (item.voltage_valid)
            begin
                low_inc = (item.voltage < cfg.low_voltage_level) ?
                          low_count_reg + 4'd1 : 4'd0;
                if (low_inc >= LOW_TICKS)
                begin
                    if (level_thermal > 8'(LEVEL_STEPS))
                        actual_next = 8'(LEVEL_STEPS / 2);
                    else if (level_thermal > 8'd1)
                        actual_next = level_thermal - 8'd1;
                    else
                        off_next = 1'b1;
                    goal_next      = actual_next;
                    low_count_next = 4'd0;
                end
                else
                begin
                    low_count_next = low_inc;
                end
            end
        end

        result_next.level          = off_next ? 8'd0 : actual_next;
        result_next.recovery_level = goal_next;
        result_next.mode_number    = mode_index_next;
        result_next.slot           = slot_next;
        result_next.config_request = cfg_req;
        result_next.shutdown       = off_next;
    end

    // State registers, updated on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_index_reg <= 3'd0;
            fast_count_reg <= 5'd0;
            slot_reg       <= 5'd0;
            actual_reg     <= 8'd0;
            goal_reg       <= 8'd0;
            hot_count_reg  <= 8'd0;
            low_count_reg  <= 4'd0;
            off_reg        <= 1'b0;
        end
        else if (accept)
        begin
            mode_index_reg <= mode_index_next;
            fast_count_reg <= fast_count_next;
            slot_reg       <= slot_next;
            actual_reg     <= actual_next;
            goal_reg       <= goal_next;
            hot_count_reg  <= hot_count_next;
            low_count_reg  <= low_count_next;
            off_reg        <= off_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

endmodule

/* bench/tb_top.sv */
module tb_top;
    import lmr_pkg::*;

    // Press code with no name of its own; the block treats it as a long press
    localparam logic [1:0] PRESS_SPARE = 2'd3;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 320;

    typedef struct {
        bit          wr;
        logic [2:0]  reg_idx;
        logic [63:0] reg_val;
        lmr_in_t     beat;
        bit          typed;
        lmr_out_t    want;
    } step_row_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    lmr_in_t     item;
    logic        result_valid;
    logic        result_stall;
    lmr_out_t    result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Shadow of the configuration and of the mode/regulation state
    lmr_cfg_t   cfg;
    logic [2:0] mode_idx;
    logic [4:0] press_cnt;
    logic [4:0] wear_slot;
    logic [7:0] lvl_now;
    logic [7:0] lvl_goal;
    logic [7:0] hot_ticks;
    logic [3:0] low_ticks;
    logic       dark;

    lmr_out_t   pending_lights[$];
    lmr_out_t   owed;
    int         lights_owed;
    int         faults;
    bit         calm;
    int         hold_req;
    step_row_t  plan[$];

    light_mode_regulator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    // Mode count as the block uses it: zero acts as one, clamp at the table size
    function automatic int modes_used();
        if (cfg.mode_count == 0)
            return 1;
        if (cfg.mode_count > MODE_SLOTS)
            return MODE_SLOTS;
        return int'(cfg.mode_count);
    endfunction

    function automatic logic [2:0] step_mode(input logic [2:0] m);
        int n;
        n = int'(m) + 1;
        return (n >= modes_used()) ? 3'd0 : 3'(n);
    endfunction

    // Light state after one beat; updates the shadow state
    function automatic lmr_out_t regulate(input lmr_in_t b);
        lmr_out_t r;
        int       n;
        logic     req;
        req = 1'b0;
        if (b.func == FUNC_POWER_ON)
        begin
            if (b.press_kind == PRESS_SHORT)
            begin
                press_cnt = 5'(press_cnt + 1);
                mode_idx  = step_mode(mode_idx);
            end
            else if (b.press_kind == PRESS_MEDIUM)
            begin
                press_cnt = '0;
                if (!cfg.medium_press_enable)
                    mode_idx = step_mode(mode_idx);
                else if (int'(mode_idx) == modes_used())
                    mode_idx = '0;
                else if (mode_idx > 0)
                    mode_idx = mode_idx - 3'd1;
                else
                    mode_idx = 3'(modes_used() - 1);
            end
            else
            begin
                press_cnt = '0;
                if (!cfg.memory_enable)
                    mode_idx = '0;
            end
            n = int'(wear_slot) + 1;
            wear_slot = (n >= WEAR_SLOTS || n > 31) ? 5'd0 : 5'(n);
            // fast-press run: request config, fall back to the first mode
            if (press_cnt > FAST_PRESS_LIMIT)
            begin
                req       = 1'b1;
                press_cnt = '0;
                mode_idx  = '0;
            end
            lvl_now   = cfg.mode_levels[8*mode_idx +: 8];
            lvl_goal  = lvl_now;
            hot_ticks = '0;
            low_ticks = '0;
            dark      = 1'b0;
        end
        else if (!dark)
        begin
            press_cnt = '0;
            // thermal step-down and recovery
            if (cfg.thermal_enable)
            begin
                if (b.temperature >= cfg.temp_limit)
                begin
                    if (hot_ticks < HOT_MAX)
                        hot_ticks = hot_ticks + 8'd1;
                    if (hot_ticks > HOT_TICKS && int'(lvl_now) > LEVEL_STEPS / 8)
                    begin
                        lvl_now   = lvl_now - 8'd1;
                        hot_ticks = '0;
                    end
                end
                else
                begin
                    hot_ticks = '0;
                    if (cfg.temp_limit >= 2 &&
                        int'(b.temperature) < int'(cfg.temp_limit) - 2 &&
                        lvl_now < lvl_goal)
                        lvl_now = lvl_now + 8'd1;
                end
            end
            else
                hot_ticks = '0;
            // low battery: step down, or go dark from the lowest level
            if (!cfg.battery_enable)
                low_ticks = '0;
            else if (b.voltage_valid)
            begin
                if (b.voltage < cfg.low_voltage_level)
                    low_ticks = low_ticks + 4'd1;
                else
                    low_ticks = '0;
                if (low_ticks >= LOW_TICKS)
                begin
                    if (int'(lvl_now) > LEVEL_STEPS)
                        lvl_now = 8'(LEVEL_STEPS / 2);
                    else if (lvl_now > 1)
                        lvl_now = lvl_now - 8'd1;
                    else
                        dark = 1'b1;
                    lvl_goal  = lvl_now;
                    low_ticks = '0;
                end
            end
        end
        r.level          = dark ? 8'd0 : lvl_now;
        r.recovery_level = lvl_goal;
        r.mode_number    = mode_idx;
        r.slot           = wear_slot;
        r.config_request = req;
        r.shutdown       = dark;
        return r;
    endfunction

    function automatic step_row_t row(input bit wr, input logic [2:0] idx,
                                      input logic [63:0] val, input lmr_in_t beat,
                                      input bit typed, input lmr_out_t want);
        step_row_t s;
        s.wr      = wr;
        s.reg_idx = idx;
        s.reg_val = val;
        s.beat    = beat;
        s.typed   = typed;
        s.want    = want;
        return s;
    endfunction

    // Offer one beat, wait for the accept, record what the light must show
    task automatic send_beat(input lmr_in_t b, input bit typed, input lmr_out_t want);
        int       gap;
        lmr_out_t guess;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       = b;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        guess = regulate(b);
        pending_lights.push_back(typed ? want : guess);
        lights_owed++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every outstanding beat has come back
    task automatic drain();
        item_valid = 1'b0;
        wait (lights_owed == 0);
        @(negedge clk);
    endtask

    // APB write: setup, access, done at the edge with pready high
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 3'b000};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_MODE_LEVELS: cfg.mode_levels         = val;
            REG_MODE_COUNT:  cfg.mode_count          = val[3:0];
            REG_MEMORY_EN:   cfg.memory_enable       = val[0];
            REG_MEDIUM_EN:   cfg.medium_press_enable = val[0];
            REG_TEMP_LIMIT:  cfg.temp_limit          = val[7:0];
            REG_LOW_VOLTAGE: cfg.low_voltage_level   = val[7:0];
            REG_THERMAL_EN:  cfg.thermal_enable      = val[0];
            REG_BATTERY_EN:  cfg.battery_enable      = val[0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            faults++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Result beats against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_lights.size() == 0)
            begin
                faults++;
                $display("%0t: result beat with nothing outstanding, expected none, actual %h",
                         $time, result);
            end
            else
            begin
                owed = pending_lights.pop_front();
                lights_owed--;
                check_field("level", owed.level, result.level);
                check_field("recovery_level", owed.recovery_level, result.recovery_level);
                check_field("mode_number", owed.mode_number, result.mode_number);
                check_field("slot", owed.slot, result.slot);
                check_field("config_request", owed.config_request, result.config_request);
                check_field("shutdown", owed.shutdown, result.shutdown);
            end
        end
    end

    // Receiver stall: a random hold before each beat, or a long one on request
    initial
    begin : rx_stall
        int k;
        result_stall = 1'b0;
        forever
        begin
            k = calm ? 0 : $urandom_range(0, 4);
            if (hold_req > 0)
            begin
                k        = hold_req;
                hold_req = 0;
            end
            if (k > 0)
            begin
                result_stall = 1'b1;
                repeat (k) @(negedge clk);
            end
            result_stall = 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        lmr_in_t     b;
        int          sc;
        int          len;
        int          done;
        logic [63:0] t_levels;
        logic [3:0]  t_count;
        logic [7:0]  t_limit;
        logic [7:0]  t_low;
        logic        t_mem;
        logic        t_med;
        logic        t_th;
        logic        t_ba;

        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        calm        = 1'b0;
        hold_req    = 0;
        faults      = 0;
        lights_owed = 0;

        cfg.mode_levels         = MODE_LEVELS_RESET;
        cfg.mode_count          = MODE_COUNT_RESET;
        cfg.memory_enable       = 1'b0;
        cfg.medium_press_enable = 1'b0;
        cfg.temp_limit          = TEMP_LIMIT_RESET;
        cfg.low_voltage_level   = LOW_VOLTAGE_RESET;
        cfg.thermal_enable      = 1'b1;
        cfg.battery_enable      = 1'b1;
        mode_idx  = '0;
        press_cnt = '0;
        wear_slot = '0;
        lvl_now   = '0;
        lvl_goal  = '0;
        hot_ticks = '0;
        low_ticks = '0;
        dark      = 1'b0;

        // Directed: reset state, every press kind, field extremes
        plan.push_back(row(0, REG_MODE_COUNT, 0, {FUNC_TICK, PRESS_SHORT, 8'd0, 8'd255, 1'b1},
                           1, {8'd0, 8'd0, 3'd0, 5'd0, 1'b0, 1'b0}));
        plan.push_back(row(0, REG_MODE_COUNT, 0, {FUNC_POWER_ON, PRESS_SHORT, 8'd0, 8'd0, 1'b0},
                           1, {8'd145, 8'd145, 3'd1, 5'd1, 1'b0, 1'b0}));
        plan.push_back(row(0, REG_MODE_COUNT, 0, {FUNC_POWER_ON, PRESS_MEDIUM, 8'd0, 8'd0, 1'b0},
                           1, {8'd124, 8'd124, 3'd2, 5'd2, 1'b0, 1'b0}));
        plan.push_back(row(0, REG_MODE_COUNT, 0, {FUNC_POWER_ON, PRESS_LONG, 8'd0, 8'd0, 1'b0},
                           1, {8'd1, 8'd1, 3'd0, 5'd3, 1'b0, 1'b0}));
        plan.push_back(row(0, REG_MODE_COUNT, 0,
                           {FUNC_POWER_ON, PRESS_SPARE, 8'd255, 8'd255, 1'b1},
                           1, {8'd1, 8'd1, 3'd0, 5'd4, 1'b0, 1'b0}));
        plan.push_back(row(0, REG_MODE_COUNT, 0, {FUNC_TICK, PRESS_SHORT, 8'd255, 8'd0, 1'b0},
                           1, {8'd1, 8'd1, 3'd0, 5'd4, 1'b0, 1'b0}));
        plan.push_back(row(0, REG_MODE_COUNT, 0, {FUNC_TICK, PRESS_SPARE, 8'd255, 8'd255, 1'b1},
                           1, {8'd1, 8'd1, 3'd0, 5'd4, 1'b0, 1'b0}));
        plan.push_back(row(0, REG_MODE_COUNT, 0, {FUNC_TICK, PRESS_SHORT, 8'd0, 8'd0, 1'b1},
                           1, {8'd1, 8'd1, 3'd0, 5'd4, 1'b0, 1'b0}));
        // ten fast presses in a row raise the config request
        repeat (9)
            plan.push_back(row(0, REG_MODE_COUNT, 0,
                               {FUNC_POWER_ON, PRESS_SHORT, 8'd0, 8'd0, 1'b0}, 0, '0));
        plan.push_back(row(0, REG_MODE_COUNT, 0, {FUNC_POWER_ON, PRESS_SHORT, 8'd0, 8'd0, 1'b0},
                           1, {8'd1, 8'd1, 3'd0, 5'd14, 1'b1, 1'b0}));
        // mode index equal to and past the mode count
        plan.push_back(row(1, REG_MODE_COUNT, 8, {FUNC_POWER_ON, PRESS_SHORT, 8'd0, 8'd0, 1'b0},
                           0, '0));
        plan.push_back(row(1, REG_MEDIUM_EN, 1, {FUNC_POWER_ON, PRESS_SHORT, 8'd0, 8'd0, 1'b0},
                           0, '0));
        plan.push_back(row(0, REG_MODE_COUNT, 0, {FUNC_POWER_ON, PRESS_SHORT, 8'd0, 8'd0, 1'b0},
                           0, '0));
        plan.push_back(row(1, REG_MODE_COUNT, 3, {FUNC_POWER_ON, PRESS_MEDIUM, 8'd0, 8'd0, 1'b0},
                           1, {8'd1, 8'd1, 3'd0, 5'd18, 1'b0, 1'b0}));
        plan.push_back(row(1, REG_MODE_COUNT, 8, {FUNC_POWER_ON, PRESS_MEDIUM, 8'd0, 8'd0, 1'b0},
                           1, {8'd0, 8'd0, 3'd7, 5'd19, 1'b0, 1'b0}));
        plan.push_back(row(1, REG_MODE_COUNT, 2, {FUNC_POWER_ON, PRESS_SHORT, 8'd0, 8'd0, 1'b0},
                           1, {8'd1, 8'd1, 3'd0, 5'd20, 1'b0, 1'b0}));

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].wr)
            begin
                drain();
                reg_write(plan[i].reg_idx, plan[i].reg_val);
            end
            send_beat(plan[i].beat, plan[i].typed, plan[i].want);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    t_levels = {$urandom, $urandom};
                    t_count  = 4'd8;
                    t_mem    = 1'b0;
                    t_med    = 1'b1;
                    t_limit  = 8'($urandom_range(40, 200));
                    t_low    = 8'($urandom_range(60, 200));
                    t_th     = 1'b1;
                    t_ba     = 1'b1;
                end
                1:
                begin
                    t_levels = '0;
                    t_count  = 4'd0;
                    t_mem    = 1'b1;
                    t_med    = 1'b0;
                    t_limit  = 8'd0;
                    t_low    = 8'd255;
                    t_th     = 1'b1;
                    t_ba     = 1'b1;
                end
                2:
                begin
                    t_levels = '1;
                    t_count  = 4'd15;
                    t_mem    = 1'b1;
                    t_med    = 1'b1;
                    t_limit  = 8'd255;
                    t_low    = 8'd0;
                    t_th     = 1'b0;
                    t_ba     = 1'b0;
                end
                3:
                begin
                    t_levels = {$urandom, $urandom};
                    t_count  = 4'd3;
                    t_mem    = 1'b0;
                    t_med    = 1'b1;
                    t_limit  = 8'd1;
                    t_low    = 8'd1;
                    t_th     = 1'b1;
                    t_ba     = 1'b1;
                end
                4:
                begin
                    // small levels reach the lowest step and shutdown quickly
                    for (int j = 0; j < 8; j++)
                        t_levels[8*j +: 8] = 8'($urandom_range(0, 10));
                    t_count  = 4'($urandom_range(1, 8));
                    t_mem    = 1'($urandom);
                    t_med    = 1'($urandom);
                    t_limit  = 8'd2;
                    t_low    = 8'($urandom);
                    t_th     = 1'b1;
                    t_ba     = 1'b1;
                end
                default:
                begin
                    t_levels = {$urandom, $urandom};
                    t_count  = 4'($urandom);
                    t_mem    = 1'($urandom);
                    t_med    = 1'($urandom);
                    t_limit  = 8'($urandom);
                    t_low    = 8'($urandom);
                    t_th     = 1'($urandom);
                    t_ba     = 1'($urandom);
                end
            endcase
            reg_write(REG_MODE_LEVELS, t_levels);
            reg_write(REG_MODE_COUNT, 64'(t_count));
            reg_write(REG_MEMORY_EN, 64'(t_mem));
            reg_write(REG_MEDIUM_EN, 64'(t_med));
            reg_write(REG_TEMP_LIMIT, 64'(t_limit));
            reg_write(REG_LOW_VOLTAGE, 64'(t_low));
            reg_write(REG_THERMAL_EN, 64'(t_th));
            reg_write(REG_BATTERY_EN, 64'(t_ba));
            done = 0;

            // long receiver hold while beats keep coming, then a full drain
            if (ph == 0)
            begin
                hold_req = 40;
                calm     = 1'b1;
                repeat (20)
                begin
                    b = lmr_in_t'($urandom);
                    send_beat(b, 0, '0);
                end
                calm = 1'b0;
                drain();
                done += 20;
            end

            // level 0 under constant heat: the hot counter saturates
            if (ph == 1)
            begin
                send_beat({FUNC_POWER_ON, PRESS_LONG, 8'd0, 8'd0, 1'b0}, 0, '0);
                repeat (280)
                    send_beat({FUNC_TICK, 2'($urandom), 8'($urandom), 8'($urandom), 1'b0},
                              0, '0);
                done += 281;
            end

            while (done < PHASE_BEATS)
            begin
                sc   = $urandom_range(0, 9);
                calm = ($urandom_range(0, 3) == 0);
                case (sc)
                    0, 1:
                    begin
                        // press burst, mostly short
                        len = $urandom_range(1, 12);
                        repeat (len)
                        begin
                            b = {FUNC_POWER_ON,
                                 ($urandom_range(0, 9) < 7) ? PRESS_SHORT : 2'($urandom),
                                 8'($urandom), 8'($urandom), 1'($urandom)};
                            send_beat(b, 0, '0);
                        end
                    end
                    2, 3:
                    begin
                        // hot run
                        len = $urandom_range(10, 40);
                        repeat (len)
                        begin
                            b = {FUNC_TICK, 2'($urandom),
                                 8'($urandom_range(255, cfg.temp_limit)),
                                 8'($urandom), 1'($urandom)};
                            send_beat(b, 0, '0);
                        end
                    end
                    4:
                    begin
                        // cool run, recovery toward the goal
                        len = $urandom_range(3, 20);
                        repeat (len)
                        begin
                            b = {FUNC_TICK, 2'($urandom),
                                 (cfg.temp_limit >= 3) ?
                                     8'($urandom_range(0, cfg.temp_limit - 3)) : 8'($urandom),
                                 8'($urandom), 1'($urandom)};
                            send_beat(b, 0, '0);
                        end
                    end
                    5, 6:
                    begin
                        // low battery run with the odd good reading
                        len = $urandom_range(8, 24);
                        repeat (len)
                        begin
                            b = {FUNC_TICK, 2'($urandom), 8'($urandom),
                                 ($urandom_range(0, 9) == 0 || cfg.low_voltage_level == 0) ?
                                     8'($urandom) :
                                     8'($urandom_range(0, cfg.low_voltage_level - 1)),
                                 1'b1};
                            send_beat(b, 0, '0);
                        end
                    end
                    default:
                    begin
                        // noise
                        len = $urandom_range(1, 10);
                        repeat (len)
                        begin
                            b = lmr_in_t'($urandom);
                            send_beat(b, 0, '0);
                        end
                    end
                endcase
                done += len;
            end
            calm = 1'b0;
        end

        drain();
        repeat (5) @(posedge clk);
        if (faults == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/lmr_pkg.sv
hw/rtl/lmr_cfg.sv
hw/rtl/light_mode_regulator.sv
bench/tb_top.sv
